>>> src/ibmw_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the indirect block map walker.
// Used by ibmw_step and indirect_block_map_walker_core; no dependencies.
package ibmw_pkg;

    localparam int unsigned DIRECT_POINTERS = 12;
    localparam int unsigned SHIFT_MIN = 8;
    localparam int unsigned SHIFT_MAX = 10;

    localparam logic [0:0] REG_ADDR_SHIFT = 1'b0;

    typedef enum logic [1:0] {
        KIND_INODE = 2'd0,
        KIND_BLOCK = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_RANGE     = 2'd1,
        STATUS_ZERO_PTR  = 2'd2,
        STATUS_READ_FAIL = 2'd3
    } t_status;

    typedef struct packed {
        logic        busy;
        logic [1:0]  levels_left;
        logic [31:0] level_offset;
    } t_walk;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] read_block;
        logic [9:0]  read_index;
        logic [31:0] mapped_block;
        t_status     status;
    } t_result;

    typedef struct packed {
        logic [31:0] ptrs;
        logic [31:0] end1;
        logic [31:0] end2;
        logic [31:0] end3;
    } t_bounds;

    // Level boundaries for a shift code of 0, 1 or 2 (shift 8, 9 or 10).
    function automatic t_bounds shift_bounds(input logic [1:0] sel);
        t_bounds     b;
        logic [4:0]  sh;
        logic [31:0] a1;
        logic [31:0] a2;
        logic [31:0] a3;
        sh = 5'(SHIFT_MIN) + {3'd0, sel};
        a1 = 32'd1 << sh;
        a2 = 32'd1 << (sh + sh);
        a3 = 32'd1 << (sh + sh + sh);
        b.ptrs = a1;
        b.end1 = 32'(DIRECT_POINTERS) + a1;
        b.end2 = 32'(DIRECT_POINTERS) + a1 + a2;
        b.end3 = 32'(DIRECT_POINTERS) + a1 + a2 + a3;
        return b;
    endfunction

endpackage

>>> src/ibmw_step.sv
`timescale 1ns / 1ps
// Combinational step of the walker: one transaction against the walk state.
// Depends on ibmw_pkg.
module ibmw_step (
    input  logic [3:0]      i_addr_shift,
    input  ibmw_pkg::t_walk i_walk,
    input  logic            i_func,
    input  logic [31:0]     i_logical_block,
    input  logic [31:0]     i_read_data,
    input  logic            i_read_failed,
    output ibmw_pkg::t_walk o_walk,
    output logic            o_emit,
    output ibmw_pkg::t_result o_result
);
    import ibmw_pkg::*;

    logic [1:0]  sel;
    logic [4:0]  shift;
    t_bounds     bnd;
    logic [1:0]  depth;
    logic [31:0] offset;
    logic [4:0]  sh_amt;
    logic [31:0] shifted;
    logic [9:0]  mask;

    always_comb begin
        if (i_addr_shift < 4'(SHIFT_MIN)) begin
            sel = 2'd0;
        end else if (i_addr_shift > 4'(SHIFT_MAX)) begin
            sel = 2'd2;
        end else begin
            sel = 2'(i_addr_shift - 4'(SHIFT_MIN));
        end
        shift = 5'(SHIFT_MIN) + {3'd0, sel};
        bnd = shift_bounds(sel);
        mask = 10'(bnd.ptrs - 32'd1);

        priority if (i_logical_block < 32'(DIRECT_POINTERS)) begin
            depth = 2'd0;
            offset = 32'd0;
        end else if (i_logical_block < bnd.end1) begin
            depth = 2'd1;
            offset = i_logical_block - 32'(DIRECT_POINTERS);
        end else if (i_logical_block < bnd.end2) begin
            depth = 2'd2;
            offset = i_logical_block - bnd.end1;
        end else begin
            depth = 2'd3;
            offset = i_logical_block - bnd.end2;
        end

        unique case (i_walk.levels_left)
            2'd2:    sh_amt = shift;
            2'd3:    sh_amt = shift + shift;
            default: sh_amt = 5'd0;
        endcase
        shifted = i_walk.level_offset >> sh_amt;

        o_walk = i_walk;
        o_emit = 1'b1;
        o_result.kind = KIND_DONE;
        o_result.read_block = 32'd0;
        o_result.read_index = 10'd0;
        o_result.mapped_block = 32'd0;
        o_result.status = STATUS_OK;

        if (!i_func) begin
            if (i_logical_block >= bnd.end3) begin
                o_walk.busy = 1'b0;
                o_walk.levels_left = 2'd0;
                o_result.status = STATUS_RANGE;
            end else begin
                o_walk.busy = 1'b1;
                o_walk.levels_left = depth;
                o_walk.level_offset = offset;
                o_result.kind = KIND_INODE;
                if (depth == 2'd0) begin
                    o_result.read_index = i_logical_block[9:0];
                end else begin
                    o_result.read_index = 10'(DIRECT_POINTERS - 1) + {8'd0, depth};
                end
            end
        end else if (!i_walk.busy) begin
            o_emit = 1'b0;
        end else if (i_read_failed) begin
            o_walk.busy = 1'b0;
            o_walk.levels_left = 2'd0;
            o_result.status = STATUS_READ_FAIL;
        end else if (i_walk.levels_left == 2'd0) begin
            o_walk.busy = 1'b0;
            o_result.mapped_block = i_read_data;
        end else if (i_read_data == 32'd0) begin
            o_walk.busy = 1'b0;
            o_walk.levels_left = 2'd0;
            o_result.status = STATUS_ZERO_PTR;
        end else begin
            o_walk.levels_left = i_walk.levels_left - 2'd1;
            o_result.kind = KIND_BLOCK;
            o_result.read_block = i_read_data;
            o_result.read_index = shifted[9:0] & mask;
        end
    end

endmodule

>>> src/indirect_block_map_walker_core.sv
`timescale 1ns / 1ps
// Top level of the indirect block map walker: input register, walk state,
// result register and configuration port. Depends on ibmw_pkg and ibmw_step.
// An input transaction is registered, then stepped, and its result registered.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset (synchronous, active low) clears the walk state and both valid flags
// and sets addr_shift to 8.
module indirect_block_map_walker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [31:0] i_logical_block,
    input  logic [31:0] i_read_data,
    input  logic        i_read_failed,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_read_block,
    output logic [9:0]  o_read_index,
    output logic [31:0] o_mapped_block,
    output logic [1:0]  o_status
);
    import ibmw_pkg::*;

    logic [3:0]  r_addr_shift;
    logic        r_in_valid;
    logic        r_func;
    logic [31:0] r_logical_block;
    logic [31:0] r_read_data;
    logic        r_read_failed;
    t_walk       r_walk;
    logic        r_out_valid;
    t_result     r_out;

    t_walk       n_walk;
    logic        step_emit;
    t_result     step_result;
    logic        out_blocked;
    logic        advance;

    assign out_blocked = r_out_valid && i_out_stall;
    assign advance = r_in_valid && !out_blocked;
    assign o_in_stall = r_in_valid && out_blocked;

    ibmw_step u_step (
        .i_addr_shift    (r_addr_shift),
        .i_walk          (r_walk),
        .i_func          (r_func),
        .i_logical_block (r_logical_block),
        .i_read_data     (r_read_data),
        .i_read_failed   (r_read_failed),
        .o_walk          (n_walk),
        .o_emit          (step_emit),
        .o_result        (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_shift <= 4'(SHIFT_MIN);
        end else if (psel && penable && pwrite && pready && paddr == {REG_ADDR_SHIFT, 2'b00}) begin
            r_addr_shift <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == {REG_ADDR_SHIFT, 2'b00}) ? {28'd0, r_addr_shift} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_func <= i_func;
            r_logical_block <= i_logical_block;
            r_read_data <= i_read_data;
            r_read_failed <= i_read_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk <= '0;
        end else if (advance) begin
            r_walk <= n_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_emit) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind = r_out.kind;
    assign o_read_block = r_out.read_block;
    assign o_read_index = r_out.read_index;
    assign o_mapped_block = r_out.mapped_block;
    assign o_status = r_out.status;

endmodule
